### hdl/ialu_pkg.sv
`timescale 1ns / 1ps
package ialu_pkg;
    localparam int WIDTH = 64;
    localparam int CW = $clog2(WIDTH + 1);

    typedef enum logic [2:0] {
        F_ADD = 3'd0,
        F_SUB = 3'd1,
        F_MUL = 3'd2,
        F_DIV = 3'd3,
        F_MOD = 3'd4,
        F_GCD = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_GCD,
        S_DONE
    } t_state;
endpackage

### hdl/integer_alu_mul_div_gcd_unit.sv
`timescale 1ns / 1ps
// Iterative 64-bit unsigned ALU: add, sub, mul (low half), div, mod, gcd.
// Add, sub, the unused codes, a zero divisor and gcd with a zero second
// operand go from accept straight to the done state. Mul runs one
// shift-add step per cycle and div/mod one shift-subtract step per cycle.
// Gcd runs one 64-step remainder pass per Euclid iteration. All work goes
// through one shared adder/subtractor, so one transaction is in flight at a
// time and o_ready is low from accept until the result is loaded into the
// output register; a stalled output holds the unit in its last state. A
// zero divisor on div gives all ones and on mod gives the dividend, both
// with o_div_by_zero set.
module integer_alu_mul_div_gcd_unit
    import ialu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [2:0]       i_func,
    input  logic [WIDTH-1:0] i_operand_a,
    input  logic [WIDTH-1:0] i_operand_b,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_result,
    output logic             o_div_by_zero
);
    t_state           r_state, n_state;
    logic [2:0]       r_func;
    logic [WIDTH-1:0] r_a, r_b, r_q, r_r, r_res;
    logic [CW-1:0]    r_cnt;
    logic             r_dz, r_odz, r_ovalid;

    logic             acc;
    logic [WIDTH-1:0] add_x, add_y, add_s;
    logic             add_sub;
    logic [WIDTH:0]   add_full;
    logic [WIDTH-1:0] r_sh;
    logic             r_top, r_ge;
    logic [WIDTH-1:0] div_rem;

    assign acc = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_result = r_res;
    assign o_div_by_zero = r_odz;

    // shared adder
    assign r_sh = {r_r[WIDTH-2:0], r_a[WIDTH-1]};
    assign r_top = r_r[WIDTH-1];
    always_comb begin
        add_x = r_a;
        add_y = r_b;
        add_sub = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                add_x = r_a;
                add_y = r_b;
                add_sub = (r_func == F_SUB);
            end
            S_MUL: begin
                add_x = r_q;
                add_y = r_b;
            end
            S_DIV, S_GCD: begin
                add_x = r_sh;
                add_y = r_b;
                add_sub = 1'b1;
            end
            S_DONE: begin
                add_x = r_a;
                add_y = r_b;
                add_sub = (r_func == F_SUB);
            end
            default: ;
        endcase
        add_full = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} +
                   {{WIDTH{1'b0}}, add_sub};
        add_s = add_full[WIDTH-1:0];
    end
    assign r_ge = add_full[WIDTH];
    assign div_rem = (r_top || r_ge) ? add_s : r_sh;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (acc) begin
                unique case (i_func)
                    F_MUL: n_state = S_MUL;
                    F_DIV, F_MOD: n_state = (i_operand_b == '0) ? S_DONE : S_DIV;
                    F_GCD: n_state = (i_operand_b == '0) ? S_DONE : S_GCD;
                    default: n_state = S_DONE;
                endcase
            end
            S_MUL, S_DIV: if (r_cnt == CW'(WIDTH - 1)) n_state = S_DONE;
            S_GCD: if (r_cnt == CW'(WIDTH - 1) && div_rem == '0) n_state = S_DONE;
            S_DONE: if (!r_ovalid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (acc) begin
                    r_func <= i_func;
                    r_a <= i_operand_a;
                    r_b <= i_operand_b;
                    r_q <= '0;
                    r_r <= '0;
                    r_cnt <= '0;
                    r_dz <= 1'b0;
                    unique case (i_func)
                        F_DIV: begin
                            if (i_operand_b == '0) begin
                                r_q <= '1;
                                r_dz <= 1'b1;
                            end
                        end
                        F_MOD: begin
                            if (i_operand_b == '0) begin
                                r_r <= i_operand_a;
                                r_dz <= 1'b1;
                            end
                        end
                        F_GCD: begin
                            if (i_operand_b == '0) r_r <= i_operand_a;
                        end
                        default: ;
                    endcase
                end
                S_MUL: begin
                    r_q <= r_a[0] ? add_s : r_q;
                    r_a <= r_a >> 1;
                    r_b <= r_b << 1;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_DIV: begin
                    r_r <= div_rem;
                    r_q <= {r_q[WIDTH-2:0], (r_top || r_ge)};
                    r_a <= r_a << 1;
                    r_cnt <= r_cnt + 1'b1;
                end
                S_GCD: begin
                    if (r_cnt == CW'(WIDTH - 1)) begin
                        // one remainder done: x <- y, y <- rem
                        r_a <= r_b;
                        r_b <= div_rem;
                        r_r <= (div_rem == '0) ? r_b : '0;
                        r_cnt <= '0;
                    end else begin
                        r_r <= div_rem;
                        r_a <= r_a << 1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: if (!r_ovalid || i_ready) begin
                    r_odz <= r_dz;
                    unique case (r_func)
                        F_ADD, F_SUB: r_res <= add_s;
                        F_MUL, F_DIV: r_res <= r_q;
                        F_MOD, F_GCD: r_res <= r_r;
                        default: r_res <= '0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // the add/sub path reads the shared adder in S_DONE with idle operands
    // held in r_a/r_b, so the adder select must honor the latched code there

`ifndef NO_ASSERTIONS
    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
        (o_valid && $stable(o_result) && $stable(o_div_by_zero)))
        else $error("output changed while stalled");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(WIDTH)) else $error("counter overrun");
`endif
endmodule
